/* rtl/core/olb_pkg.sv */
// types and constants shared by the ordered list buffer modules
`timescale 1ns / 1ps
`default_nettype none

package olb_pkg;

  localparam int WordW = 32;
  // position width, covers a fill of up to 127 entries
  localparam int PosW  = 7;

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_MAXIMUM = 3'd3;
  localparam logic [2:0] CMD_REVERSE = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAX,
    S_REV
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE,
    OP_SWAP
  } cell_op_e;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [2:0]              index;
    logic signed [WordW-1:0] value;
  } olb_req_t;

  typedef struct packed {
    status_e                 status;
    logic signed [WordW-1:0] data;
    logic [3:0]              count;
  } olb_rsp_t;

  typedef struct packed {
    cell_op_e          op;
    logic [PosW-1:0]   idx;
    logic [PosW-1:0]   fill;
    logic              parity;
    logic [WordW-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/ordered_list_buffer_core.sv */
// top level of the ordered list buffer: control and the row of cells
`timescale 1ns / 1ps
`default_nettype none

// A command is taken as one transaction when start is high and busy is low. Append,
// insert, delete and read give the result on rsp_o with done_o high in the cycle
// after the command is taken, and busy stays low. Maximum on a list of n entries
// rotates the row through cell 0 once, keeping busy high meanwhile; the result
// follows in the cycle after the last rotation step. Reverse on n entries runs n rounds
// of neighbor swaps along the row with busy high. An empty maximum and a reverse on at
// most one entry answer as append does. Each result is shown for one cycle only and
// cannot be held off, and a new command may be taken in that same cycle.
module ordered_list_buffer_core #(
  parameter int CAPACITY = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire olb_pkg::olb_req_t req_i,
  output logic                   done_o,
  output olb_pkg::olb_rsp_t      rsp_o
);
  import olb_pkg::*;

  localparam int              FillW = $clog2(CAPACITY + 1);
  localparam int              IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int              NRead = (CAPACITY < 8) ? CAPACITY : 8;
  localparam logic [PosW-1:0] CapL  = PosW'(CAPACITY);

  state_e                  state_q, state_d;
  logic [FillW-1:0]        fill_q, fill_d;
  logic [FillW-1:0]        step_q, step_d;
  logic signed [WordW-1:0] max_q, max_d;
  logic                    done_q, done_d;
  olb_rsp_t                rsp_q, rsp_d;

  cell_ctrl_t              ctrl;
  logic [WordW-1:0]        word [CAPACITY];
  logic [WordW-1:0]        rd_word;
  logic signed [WordW-1:0] max_cur;
  logic [PosW-1:0]         fill_ext;
  logic [PosW-1:0]         idx_ext;
  logic                    accept;
  logic                    last_step;

  assign fill_ext  = PosW'(fill_q);
  assign idx_ext   = PosW'(req_i.index);
  assign accept    = start && (state_q == S_IDLE);
  assign last_step = (step_q == fill_q - FillW'(1));

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < NRead; k++) begin
      if (req_i.index == 3'(k)) rd_word = word[IdxW'(k)];
    end
  end

  assign max_cur = ($signed(word[0]) > max_q) ? $signed(word[0]) : max_q;

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WordW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = word[g];
    end else begin : g_inner_l
      assign left_w = word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = word[g];
    end else begin : g_inner_r
      assign right_w = word[g+1];
    end
    olb_cell #(
      .POS(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (word[0]),
      .word_o (word[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && req_i.cmd == CMD_MAXIMUM && fill_q != '0) begin
          state_d = S_MAX;
        end else if (accept && req_i.cmd == CMD_REVERSE && fill_ext > PosW'(1)) begin
          state_d = S_REV;
        end
      end
      S_MAX: begin
        if (last_step) state_d = S_IDLE;
      end
      S_REV: begin
        if (last_step) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.idx    = idx_ext;
    ctrl.fill   = fill_ext;
    ctrl.parity = step_q[0];
    ctrl.value  = req_i.value;
    fill_d      = fill_q;
    step_d      = step_q;
    max_d       = max_q;
    done_d      = 1'b0;
    rsp_d.status = STATUS_OK;
    rsp_d.data   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (req_i.cmd)
            CMD_APPEND: begin
              if (fill_ext >= CapL) begin
                rsp_d.status = STATUS_FULL;
              end else begin
                ctrl.op = OP_APPEND;
                fill_d  = fill_q + FillW'(1);
              end
            end
            CMD_INSERT: begin
              if (fill_ext >= CapL) begin
                rsp_d.status = STATUS_FULL;
              end else if (idx_ext > fill_ext) begin
                rsp_d.status = STATUS_RANGE;
              end else begin
                ctrl.op = OP_INSERT;
                fill_d  = fill_q + FillW'(1);
              end
            end
            CMD_DELETE: begin
              if (fill_q == '0) begin
                rsp_d.status = STATUS_EMPTY;
                rsp_d.data   = '1;
              end else if (idx_ext >= fill_ext) begin
                rsp_d.status = STATUS_RANGE;
              end else begin
                rsp_d.data = rd_word;
                ctrl.op    = OP_DELETE;
                fill_d     = fill_q - FillW'(1);
              end
            end
            CMD_MAXIMUM: begin
              if (fill_q != '0) begin
                done_d = 1'b0;
                max_d  = '0;
                step_d = '0;
              end
            end
            CMD_REVERSE: begin
              if (fill_ext > PosW'(1)) begin
                done_d = 1'b0;
                step_d = '0;
              end
            end
            CMD_READ: begin
              if (fill_q == '0) begin
                rsp_d.status = STATUS_EMPTY;
              end else if (idx_ext >= fill_ext) begin
                rsp_d.status = STATUS_RANGE;
              end else begin
                rsp_d.data = rd_word;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_MAX: begin
        ctrl.op = OP_ROTATE;
        max_d   = max_cur;
        step_d  = step_q + FillW'(1);
        if (last_step) begin
          done_d     = 1'b1;
          rsp_d.data = max_cur;
        end
      end
      S_REV: begin
        ctrl.op = OP_SWAP;
        step_d  = step_q + FillW'(1);
        if (last_step) done_d = 1'b1;
      end
      default: ctrl.op = OP_HOLD;
    endcase
    rsp_d.count = 4'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    max_q  <= max_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_ext <= CapL)
    else $error("fill above capacity");

  a_fill_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(fill_q))
    else $error("fill changed during a multi-cycle command");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (step_q < fill_q))
    else $error("step counter past fill");

  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.cmd != CMD_MAXIMUM && req_i.cmd != CMD_REVERSE)
      |=> done_o)
    else $error("single-cycle command gave no result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

endmodule

`default_nettype wire

/* rtl/core/olb_cell.sv */
// one storage cell of the list row
`timescale 1ns / 1ps
`default_nettype none

module olb_cell #(
  parameter int POS = 0
) (
  input  wire logic                        clk_i,
  input  wire olb_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [olb_pkg::WordW-1:0]   left_i,
  input  wire logic [olb_pkg::WordW-1:0]   right_i,
  input  wire logic [olb_pkg::WordW-1:0]   head_i,
  output logic      [olb_pkg::WordW-1:0]   word_o
);
  import olb_pkg::*;

  localparam logic [PosW-1:0] PosL = PosW'(POS);
  localparam logic [PosW-1:0] PosN = PosW'(POS + 1);

  logic [WordW-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      OP_APPEND: begin
        if (ctrl_i.fill == PosL) word_d = ctrl_i.value;
      end
      OP_INSERT: begin
        if (ctrl_i.idx == PosL) begin
          word_d = ctrl_i.value;
        end else if (ctrl_i.idx < PosL && PosL <= ctrl_i.fill) begin
          word_d = left_i;
        end
      end
      OP_DELETE: begin
        if (ctrl_i.idx <= PosL && PosN < ctrl_i.fill) word_d = right_i;
      end
      OP_ROTATE: begin
        if (PosN < ctrl_i.fill) begin
          word_d = right_i;
        end else if (PosN == ctrl_i.fill) begin
          word_d = head_i;
        end
      end
      OP_SWAP: begin
        // left member of a pair takes its right neighbor, right member its left
        if (PosL[0] == ctrl_i.parity) begin
          if (PosN < ctrl_i.fill) word_d = right_i;
        end else if (PosL != '0 && PosL < ctrl_i.fill) begin
          word_d = left_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire
